### hw/rtl/lhrs_pkg.sv
// Shared types and constants for the link health and report scheduler.
package lhrs_pkg;

   localparam int unsigned CsrIndexWidth = 8;

   localparam logic [CsrIndexWidth-1:0] REG_OFFLINE_THRESHOLD = 8'd0;
   localparam logic [CsrIndexWidth-1:0] REG_REPORT_PERIOD     = 8'd1;

   localparam logic [7:0]  THRESHOLD_RESET = 8'd3;
   localparam logic [31:0] PERIOD_RESET    = 32'd5000;
   localparam logic [31:0] MIN_PERIOD_MS   = 32'd1000;
   localparam logic [15:0] NONE_SEEN       = 16'hFFFF;
   localparam logic [7:0]  COUNT_MAX       = 8'hFF;

   typedef enum logic [1:0] {
      CMD_STATUS  = 2'd0,
      CMD_RELAY   = 2'd1,
      CMD_POLL    = 2'd2,
      CMD_TRIGGER = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CAUSE_NONE     = 2'd0,
      CAUSE_EVENT    = 2'd1,
      CAUSE_PERIODIC = 2'd2
   } cause_type;

   typedef struct packed {
      cmd_type     command;
      logic        sensor_a_ok;
      logic        sensor_b_ok;
      logic        relay_link_ok;
      logic [15:0] relay_outputs;
      logic [31:0] now_ms;
      logic        link_idle;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  offline_flags;
      logic        report_fire;
      cause_type   report_cause;
      logic [31:0] report_sequence;
      logic        event_waiting;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]  offline_threshold;
      logic [31:0] report_period_ms;
   } cfg_type;

endpackage

### hw/rtl/lhrs_csr.sv
// Configuration registers: failure threshold and report period.
module lhrs_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lhrs_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [31:0]                           csr_wdata,
   output lhrs_pkg::cfg_type                     cfg
);

   logic [7:0]  threshold_ff, threshold_in;
   logic [31:0] period_ff, period_in;
   logic        write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   always_comb begin
      threshold_in = threshold_ff;
      period_in    = period_ff;
      if (write) begin
         unique case (csr_index)
            lhrs_pkg::REG_OFFLINE_THRESHOLD: begin
               threshold_in = csr_wdata[7:0];
            end
            lhrs_pkg::REG_REPORT_PERIOD: begin
               // Periods shorter than the minimum are dropped.
               if (csr_wdata >= lhrs_pkg::MIN_PERIOD_MS) begin
                  period_in = csr_wdata;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= lhrs_pkg::THRESHOLD_RESET;
         period_ff    <= lhrs_pkg::PERIOD_RESET;
      end else begin
         threshold_ff <= threshold_in;
         period_ff    <= period_in;
      end
   end

   assign cfg.offline_threshold = threshold_ff;
   assign cfg.report_period_ms  = period_ff;

   period_floor_a: assert property (@(posedge clock) disable iff (reset)
      period_ff >= lhrs_pkg::MIN_PERIOD_MS)
      else $error("report period below minimum");

   ignored_write_a: assert property (@(posedge clock) disable iff (reset)
      write && csr_index != lhrs_pkg::REG_OFFLINE_THRESHOLD
            && csr_index != lhrs_pkg::REG_REPORT_PERIOD
      |=> $stable(threshold_ff) && $stable(period_ff))
      else $error("write beyond register list changed a register");

   short_period_a: assert property (@(posedge clock) disable iff (reset)
      write && csr_index == lhrs_pkg::REG_REPORT_PERIOD
            && csr_wdata < lhrs_pkg::MIN_PERIOD_MS
      |=> $stable(period_ff))
      else $error("short period write was taken");

endmodule

### hw/rtl/lhrs_core.sv
// Health counters, event tracking and report scheduling for one item.
module lhrs_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  lhrs_pkg::req_item_type  item,
   input  lhrs_pkg::cfg_type       cfg,
   output lhrs_pkg::rsp_item_type  result
);

   logic [7:0]  fail_a_ff, fail_a_in;
   logic [7:0]  fail_b_ff, fail_b_in;
   logic [7:0]  fail_r_ff, fail_r_in;
   logic [2:0]  offline_ff, offline_in;
   logic        pending_ff, pending_in;
   logic [15:0] prev_out_ff, prev_out_in;
   logic [31:0] last_time_ff, last_time_in;
   logic [31:0] seq_ff, seq_in;
   logic [31:0] elapsed;
   logic        fire;
   lhrs_pkg::cause_type cause;

   function automatic logic [7:0] count_next(input logic [7:0] cnt, input logic ok);
      logic [7:0] res;
      if (ok) begin
         res = 8'd0;
      end else if (cnt == lhrs_pkg::COUNT_MAX) begin
         res = cnt;
      end else begin
         res = cnt + 8'd1;
      end
      return res;
   endfunction

   function automatic logic flag_next(input logic flag, input logic ok,
                                      input logic [7:0] cnt, input logic [7:0] thr);
      logic res;
      if (ok) begin
         res = 1'b0;
      end else if (cnt >= thr) begin
         res = 1'b1;
      end else begin
         res = flag;
      end
      return res;
   endfunction

   assign elapsed = item.now_ms - last_time_ff;

   always_comb begin
      fail_a_in    = fail_a_ff;
      fail_b_in    = fail_b_ff;
      fail_r_in    = fail_r_ff;
      offline_in   = offline_ff;
      pending_in   = pending_ff;
      prev_out_in  = prev_out_ff;
      last_time_in = last_time_ff;
      seq_in       = seq_ff;
      fire         = 1'b0;
      cause        = lhrs_pkg::CAUSE_NONE;
      unique case (item.command)
         lhrs_pkg::CMD_STATUS: begin
            fail_a_in = count_next(fail_a_ff, item.sensor_a_ok);
            fail_b_in = count_next(fail_b_ff, item.sensor_b_ok);
            fail_r_in = count_next(fail_r_ff, item.relay_link_ok);
            offline_in[0] = flag_next(offline_ff[0], item.sensor_a_ok, fail_a_in,
                                      cfg.offline_threshold);
            offline_in[1] = flag_next(offline_ff[1], item.sensor_b_ok, fail_b_in,
                                      cfg.offline_threshold);
            offline_in[2] = flag_next(offline_ff[2], item.relay_link_ok, fail_r_in,
                                      cfg.offline_threshold);
            if (offline_in != offline_ff) begin
               pending_in = 1'b1;
            end
         end
         lhrs_pkg::CMD_RELAY: begin
            if (prev_out_ff != lhrs_pkg::NONE_SEEN && prev_out_ff != item.relay_outputs) begin
               pending_in = 1'b1;
            end
            prev_out_in = item.relay_outputs;
         end
         lhrs_pkg::CMD_POLL: begin
            // A pending event report takes priority over the periodic one.
            if (item.link_idle && pending_ff) begin
               pending_in   = 1'b0;
               seq_in       = seq_ff + 32'd1;
               last_time_in = item.now_ms;
               fire         = 1'b1;
               cause        = lhrs_pkg::CAUSE_EVENT;
            end else if (item.link_idle && elapsed >= cfg.report_period_ms) begin
               seq_in       = seq_ff + 32'd1;
               last_time_in = item.now_ms;
               fire         = 1'b1;
               cause        = lhrs_pkg::CAUSE_PERIODIC;
            end
         end
         lhrs_pkg::CMD_TRIGGER: begin
            pending_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_a_ff    <= 8'd0;
         fail_b_ff    <= 8'd0;
         fail_r_ff    <= 8'd0;
         offline_ff   <= 3'd0;
         pending_ff   <= 1'b0;
         prev_out_ff  <= lhrs_pkg::NONE_SEEN;
         last_time_ff <= 32'd0;
         seq_ff       <= 32'd0;
      end else if (step) begin
         fail_a_ff    <= fail_a_in;
         fail_b_ff    <= fail_b_in;
         fail_r_ff    <= fail_r_in;
         offline_ff   <= offline_in;
         pending_ff   <= pending_in;
         prev_out_ff  <= prev_out_in;
         last_time_ff <= last_time_in;
         seq_ff       <= seq_in;
      end
   end

   assign result.offline_flags   = offline_in;
   assign result.report_fire     = fire;
   assign result.report_cause    = cause;
   assign result.report_sequence = seq_in;
   assign result.event_waiting   = pending_in;

   seq_advance_a: assert property (@(posedge clock) disable iff (reset)
      step && fire |=> seq_ff == $past(seq_ff) + 32'd1)
      else $error("report sequence did not advance on a report");

   seq_hold_a: assert property (@(posedge clock) disable iff (reset)
      step && !fire |=> $stable(seq_ff))
      else $error("report sequence moved without a report");

   trigger_pending_a: assert property (@(posedge clock) disable iff (reset)
      step && item.command == lhrs_pkg::CMD_TRIGGER |=> pending_ff)
      else $error("trigger did not raise the pending event");

   event_clears_a: assert property (@(posedge clock) disable iff (reset)
      step && cause == lhrs_pkg::CAUSE_EVENT |=> !pending_ff)
      else $error("event report left the event pending");

endmodule

### hw/rtl/link_health_and_report_scheduler_top.sv
// Link health and report scheduler, top level.
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle without rsp_stall; while a result waits, one more is held.
// Reset clears all health, event and report state and loads the register defaults.
// No clearing pass: the block accepts items in the first cycle after reset.
module link_health_and_report_scheduler_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_command,
   input  logic                                  req_sensor_a_ok,
   input  logic                                  req_sensor_b_ok,
   input  logic                                  req_relay_link_ok,
   input  logic [15:0]                           req_relay_outputs,
   input  logic [31:0]                           req_now_ms,
   input  logic                                  req_link_idle,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [2:0]                            rsp_offline_flags,
   output logic                                  rsp_report_fire,
   output logic [1:0]                            rsp_report_cause,
   output logic [31:0]                           rsp_report_sequence,
   output logic                                  rsp_event_waiting,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lhrs_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [31:0]                           csr_wdata
);

   lhrs_pkg::cfg_type      cfg;
   lhrs_pkg::req_item_type in_ff, in_in;
   logic                   in_valid_ff, in_valid_in;
   lhrs_pkg::rsp_item_type out_ff, out_in;
   logic                   out_valid_ff, out_valid_in;
   lhrs_pkg::rsp_item_type result;
   logic                   step;
   logic                   req_take;

   lhrs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lhrs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_ff),
      .cfg    (cfg),
      .result (result)
   );

   // The held item moves on when the result register is empty or being taken.
   assign step      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_in.command       = lhrs_pkg::cmd_type'(req_command);
      in_in.sensor_a_ok   = req_sensor_a_ok;
      in_in.sensor_b_ok   = req_sensor_b_ok;
      in_in.relay_link_ok = req_relay_link_ok;
      in_in.relay_outputs = req_relay_outputs;
      in_in.now_ms        = req_now_ms;
      in_in.link_idle     = req_link_idle;
      in_valid_in         = req_take || (in_valid_ff && !step);
      out_in              = result;
      out_valid_in        = step || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= in_in;
      end
      if (step) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_offline_flags   = out_ff.offline_flags;
   assign rsp_report_fire     = out_ff.report_fire;
   assign rsp_report_cause    = out_ff.report_cause;
   assign rsp_report_sequence = out_ff.report_sequence;
   assign rsp_event_waiting   = out_ff.event_waiting;

   no_overwrite_a: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |-> !step)
      else $error("stalled result overwritten");

   no_drop_a: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_ff))
      else $error("held item lost before it moved on");

   fire_cause_a: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.report_fire == (out_ff.report_cause != lhrs_pkg::CAUSE_NONE)))
      else $error("report fire and cause disagree");

endmodule
